@@ rtl/lrch_pkg.sv @@
package lrch_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int IN_W    = 32;
  localparam int REP_W   = 16;
  localparam int LIMIT_W = 17;
  localparam int RUN_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_RUNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_RUNS = 2'd2;

  localparam logic [LIMIT_W-1:0] LOSS_LIMIT_RESET   = '0;
  localparam logic [RUN_W-1:0]   TRIGGER_RUNS_RESET = 8'd5;
  localparam logic [RUN_W-1:0]   RECOVER_RUNS_RESET = 8'd10;
  localparam logic [RUN_W-1:0]   RUN_MAX            = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

@@ rtl/lrch_if.sv @@
interface lrch_in_if;
  logic                         valid;
  logic                         ready;
  logic [lrch_pkg::IN_W-1:0]    received_count;
  logic [lrch_pkg::IN_W-1:0]    lost_count;

  modport source (output valid, output received_count, output lost_count, input ready);
  modport sink   (input valid, input received_count, input lost_count, output ready);
endinterface

interface lrch_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrch_pkg::REP_W-1:0]    reported_received;
  logic [lrch_pkg::REP_W-1:0]    reported_lost;
  logic [lrch_pkg::LIMIT_W-1:0]  loss_fraction;
  logic                          honest_active;
  logic                          was_clamped;

  modport source (output valid, output reported_received, output reported_lost,
                  output loss_fraction, output honest_active, output was_clamped,
                  input ready);
  modport sink   (input valid, input reported_received, input reported_lost,
                  input loss_fraction, input honest_active, input was_clamped,
                  output ready);
endinterface

@@ rtl/lrch_ctrl.sv @@
module lrch_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lrch_pkg::sts_t   sts,
  output lrch_pkg::cmd_t   cmd
);

  lrch_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrch_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      lrch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lrch_pkg::ST_DIV;
        end
      end
      lrch_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = lrch_pkg::ST_DONE;
        end
      end
      lrch_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lrch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrch_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/lrch_datapath.sv @@
module lrch_datapath #(
  parameter int COUNT_BITS = lrch_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = lrch_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lrch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrch_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [lrch_pkg::IN_W-1:0]         in_received_count,
  input  logic [lrch_pkg::IN_W-1:0]         in_lost_count,
  input  lrch_pkg::cmd_t                    cmd,
  output lrch_pkg::sts_t                    sts,
  output logic [lrch_pkg::REP_W-1:0]        out_reported_received,
  output logic [lrch_pkg::REP_W-1:0]        out_reported_lost,
  output logic [lrch_pkg::LIMIT_W-1:0]      out_loss_fraction,
  output logic                              out_honest_active,
  output logic                              out_was_clamped
);

  localparam int CW    = (COUNT_BITS < lrch_pkg::IN_W) ? COUNT_BITS : lrch_pkg::IN_W;
  localparam int TW    = CW + 1;
  localparam int RW    = CW + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int PW    = lrch_pkg::LIMIT_W + TW;
  localparam int NW    = CW + FRAC_BITS;
  localparam int CMPW  = (PW > NW) ? PW : NW;
  localparam int CNTW  = $clog2(FRAC_BITS + 1);
  localparam int RUN_W = lrch_pkg::RUN_W;

  logic [lrch_pkg::LIMIT_W-1:0] loss_limit_r;
  logic [RUN_W-1:0]             trigger_runs_r;
  logic [RUN_W-1:0]             recover_runs_r;

  logic [CW-1:0]   rx_r;
  logic [CW-1:0]   lo_r;
  logic [TW-1:0]   total_r;
  logic [RW-1:0]   rem_r;
  logic [QW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic [PW-1:0]   prod_r;

  logic             honest_r, honest_nxt;
  logic [RUN_W-1:0] over_run_r, over_run_nxt;
  logic [RUN_W-1:0] under_run_r, under_run_nxt;

  logic [lrch_pkg::REP_W-1:0]   rep_rx_r;
  logic [lrch_pkg::REP_W-1:0]   rep_lo_r;
  logic [lrch_pkg::LIMIT_W-1:0] frac_r;
  logic                         clamped_r;

  logic [RW-1:0]             trial;
  logic                      trial_ge;
  logic                      over;
  logic                      in_band;
  logic                      clamp;
  logic [lrch_pkg::REP_W-1:0] clamp_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_limit_r   <= lrch_pkg::LOSS_LIMIT_RESET;
      trigger_runs_r <= lrch_pkg::TRIGGER_RUNS_RESET;
      recover_runs_r <= lrch_pkg::RECOVER_RUNS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lrch_pkg::REG_LOSS_LIMIT:   loss_limit_r   <= cfg_wdata;
        lrch_pkg::REG_TRIGGER_RUNS: trigger_runs_r <= cfg_wdata[RUN_W-1:0];
        lrch_pkg::REG_RECOVER_RUNS: recover_runs_r <= cfg_wdata[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Restoring division of lost * one by the total. The dividend's low bits
  // are all zero, so the first step compares the lost count itself and each
  // later step doubles the partial remainder.
  assign trial    = (cnt_r == '0) ? rem_r : (rem_r << 1);
  assign trial_ge = trial >= RW'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_r    <= CW'(in_received_count);
      lo_r    <= CW'(in_lost_count);
      total_r <= TW'(CW'(in_received_count)) + TW'(CW'(in_lost_count));
      rem_r   <= RW'(CW'(in_lost_count));
      quo_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? (trial - RW'(total_r)) : trial;
      quo_r  <= {quo_r[QW-2:0], trial_ge};
      prod_r <= PW'(loss_limit_r) * PW'(total_r);
    end
  end

  assign sts.div_last = (cnt_r == CNTW'(FRAC_BITS));

  assign over    = (CMPW'(lo_r) << FRAC_BITS) > CMPW'(prod_r);
  assign in_band = (loss_limit_r != '0) && ((loss_limit_r >> FRAC_BITS) == '0);

  always_comb begin
    honest_nxt    = honest_r;
    over_run_nxt  = over_run_r;
    under_run_nxt = under_run_r;
    if (in_band) begin
      if (over) begin
        under_run_nxt = '0;
        if (!honest_r) begin
          over_run_nxt = (over_run_r != lrch_pkg::RUN_MAX) ? over_run_r + 1'b1 : over_run_r;
          if (over_run_nxt >= trigger_runs_r) begin
            honest_nxt = 1'b1;
          end
        end
      end else begin
        over_run_nxt = '0;
        if (honest_r) begin
          under_run_nxt = (under_run_r != lrch_pkg::RUN_MAX) ? under_run_r + 1'b1 : under_run_r;
          if (under_run_nxt >= recover_runs_r) begin
            honest_nxt    = 1'b0;
            under_run_nxt = '0;
          end
        end
      end
    end
  end

  assign clamp    = !honest_nxt && over;
  assign clamp_lo = lrch_pkg::REP_W'(prod_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      honest_r    <= 1'b0;
      over_run_r  <= '0;
      under_run_r <= '0;
    end else if (cmd.commit) begin
      honest_r    <= honest_nxt;
      over_run_r  <= over_run_nxt;
      under_run_r <= under_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rep_lo_r  <= clamp ? clamp_lo : lrch_pkg::REP_W'(lo_r);
      rep_rx_r  <= clamp ? (lrch_pkg::REP_W'(total_r) - clamp_lo)
                         : lrch_pkg::REP_W'(rx_r);
      frac_r    <= (total_r == '0) ? '0 : lrch_pkg::LIMIT_W'(quo_r);
      clamped_r <= clamp;
    end
  end

  assign out_reported_received = rep_rx_r;
  assign out_reported_lost     = rep_lo_r;
  assign out_loss_fraction     = frac_r;
  assign out_honest_active     = honest_r;
  assign out_was_clamped       = clamped_r;

endmodule

@@ rtl/loss_report_clamp_hysteresis.sv @@
// Loss-report clamp with hysteresis. Each input transaction carries one
// interval's received and lost counts; each output transaction carries the
// counts to report, the measured loss in Q1.FRAC_BITS, the honest-mode flag
// and a clamp flag. One transaction is processed at a time. The counts are
// captured at the accepting edge and go to the bit-serial restoring divider
// that forms the loss fraction. A commit step then updates the hysteresis
// state and loads the output register; it is held off while an earlier
// result still waits for out_chan.ready. The next transaction can be
// accepted in the cycle in which the result first shows valid, even while
// that result still waits for out_chan.ready. Configuration writes must
// only be issued while no transaction is in flight.
module loss_report_clamp_hysteresis #(
  parameter int COUNT_BITS = lrch_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = lrch_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lrch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrch_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lrch_in_if.sink                         in_chan,
  lrch_out_if.source                      out_chan
);

  lrch_pkg::cmd_t cmd;
  lrch_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  lrch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrch_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_received_count     (in_chan.received_count),
    .in_lost_count         (in_chan.lost_count),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_reported_received (out_chan.reported_received),
    .out_reported_lost     (out_chan.reported_lost),
    .out_loss_fraction     (out_chan.loss_fraction),
    .out_honest_active     (out_chan.honest_active),
    .out_was_clamped       (out_chan.was_clamped)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

`ifndef SYNTHESIS
  a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_chan.valid || out_chan.ready))
    else $error("result committed over an untaken output transaction");

  a_clamp_not_honest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.was_clamped) |-> !out_chan.honest_active)
    else $error("clamp applied while honest mode is active");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("second transaction accepted while one is in flight");
`endif

endmodule
